// File: rtl/cpml_field_update_core_macros.svh
// Assertion helpers for the CPML field update core.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef CPML_FIELD_UPDATE_CORE_MACROS_SVH
`define CPML_FIELD_UPDATE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPML_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPML_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpml_pkg.sv
package cpml_pkg;

  localparam int unsigned DEF_CELL_COUNT = 4096;
  localparam int unsigned CELL_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_DATA_W-1:0] INV_D_RESET = 31'd65536;
  localparam logic [CFG_DATA_W-1:0] TIME_STEP_RESET = 31'd32768;

  localparam logic [2:0] MODE_EX = 3'd0;
  localparam logic [2:0] MODE_EY = 3'd1;
  localparam logic [2:0] MODE_EZ = 3'd2;
  localparam logic [2:0] MODE_HX = 3'd3;
  localparam logic [2:0] MODE_HY = 3'd4;
  localparam logic [2:0] MODE_HZ = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_DX,
    CFG_INV_DY,
    CFG_INV_DZ,
    CFG_TIME_STEP
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]              mode;
    logic [CELL_W-1:0]       cell_req;
    logic signed [31:0]      field_old;
    logic signed [31:0]      diff1;
    logic signed [31:0]      diff2;
    logic [16:0]             decay1;
    logic [16:0]             decay2;
    logic signed [31:0]      gain1;
    logic signed [31:0]      gain2;
    logic [16:0]             inv_kappa1;
    logic [16:0]             inv_kappa2;
    logic [CFG_DATA_W-1:0]   inv_material;
  } in_t;

  typedef struct packed {
    logic signed [31:0] field_new;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] second;
    logic signed [31:0] first;
  } psi_pair_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } fx_t;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Clamp a wide signed value to 32 bits and report whether it clipped.
  function automatic fx_t fx_sat64(input logic signed [63:0] v);
    fx_t r;
    if (v > SAT_MAX) begin
      r.sat = 1'b1;
      r.val = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r.sat = 1'b1;
      r.val = SAT_MIN[31:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Q15.16 product rescale: floor division by 2^16, then clamp.
  function automatic fx_t fx_shift_sat(input logic signed [63:0] p);
    return fx_sat64(p >>> 16);
  endfunction

endpackage

// File: rtl/cpml_psi_mem.sv
module cpml_psi_mem #(
  parameter int unsigned CELL_COUNT = cpml_pkg::DEF_CELL_COUNT,
  localparam int unsigned ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output cpml_pkg::psi_pair_t   rd_data_o,
  input  logic                  wr_en_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  cpml_pkg::psi_pair_t   wr_data_i,
  output logic                  busy_o
);
  import cpml_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  psi_pair_t         mem [CELL_COUNT];
  psi_pair_t         rd_data_q;
  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  // After reset every entry is swept to zero, one per cycle.
  always_comb begin
    clr_d = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A read at the address being written returns the old entry; the
  // pipeline forwards the newer value itself.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o = clr_q;

endmodule

// File: rtl/cpml_field_update_core.sv
// CPML field update core. One transaction enters per clock cycle unless stalled,
// and its result passes stages one to six into the output register; the rate is set
// by the psi read-modify-write, whose loop closes in stage three (decay multiply,
// add and clamp) with the fresh value forwarded from write-back, so updates to the
// same cell may follow each other in consecutive cycles. Both psi values of a cell
// live in one 64-bit wide memory with one read and one write port. After reset the
// memory is cleared entry by entry, during which the input stays stalled;
// configuration writes are taken at any time but must only be issued while the core
// is idle. A result waiting in the output register stalls the whole pipeline, and
// with it the input, only while the last stage also holds a transaction.
`include "cpml_field_update_core_macros.svh"

module cpml_field_update_core #(
  parameter int unsigned CELL_COUNT = cpml_pkg::DEF_CELL_COUNT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpml_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cpml_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cpml_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cpml_pkg::out_t                      out_data_o
);
  import cpml_pkg::*;

  localparam int unsigned ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned IDX_W = (ADDR_W > CELL_W) ? ADDR_W : CELL_W;
  localparam int unsigned CNT_W = $clog2(CELL_COUNT + 1);
  localparam int unsigned CMP_W = (CNT_W > CELL_W) ? CNT_W : CELL_W;

  typedef struct packed {
    logic              upd;
    logic              wr;
    logic              in_range;
    logic              add;
    logic [CELL_W-1:0] cell_idx;
  } ctl_t;

  // Configuration.
  logic [CFG_DATA_W-1:0] inv_dx_q, inv_dy_q, inv_dz_q, time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dx_q <= INV_D_RESET;
      inv_dy_q <= INV_D_RESET;
      inv_dz_q <= INV_D_RESET;
      time_step_q <= TIME_STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_INV_DX:    inv_dx_q <= cfg_data_i;
        CFG_INV_DY:    inv_dy_q <= cfg_data_i;
        CFG_INV_DZ:    inv_dz_q <= cfg_data_i;
        CFG_TIME_STEP: time_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic advance, accept, mem_busy, pipe_busy;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, out_valid_q, out_valid_d;

  assign advance = !(out_valid_q && out_stall_i && v6_q);
  assign in_stall_o = mem_busy || !advance;
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_d = (advance && v6_q) ? 1'b1 : (out_valid_q && out_stall_i);
  assign pipe_busy = v1_q || v2_q || v3_q || v4_q || v5_q || v6_q || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Acceptance: decode the item and start the psi read.
  ctl_t              ctl_in;
  logic [IDX_W-1:0]  rd_idx, wr_idx;
  psi_pair_t         psi_rd;

  always_comb begin
    ctl_in.cell_idx = in_data_i.cell_req;
    ctl_in.in_range = (CMP_W'(in_data_i.cell_req) < CMP_W'(CELL_COUNT));
    ctl_in.upd = in_data_i.mode inside {MODE_EX, MODE_EY, MODE_EZ, MODE_HX, MODE_HY, MODE_HZ};
    ctl_in.add = in_data_i.mode inside {MODE_EX, MODE_EY, MODE_EZ};
    ctl_in.wr = ctl_in.upd && ctl_in.in_range;
  end

  assign rd_idx = IDX_W'(in_data_i.cell_req);

  // Stage registers (payload, no reset).
  in_t               s1_q, s2_q, s3_q;
  ctl_t              c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic signed [63:0] t1r_q, t2r_q, coefr_q;
  psi_pair_t         psi2_q, psi3_q, psin4_q;
  logic signed [63:0] gt1r_q, gt2r_q, st1r_q, st2r_q;
  logic signed [31:0] coef3_q, coef4_q, coef5_q;
  logic              f3_q, f4_q, f5_q, f6_q;
  logic signed [31:0] sk1_q, sk2_q, sum5_q;
  logic signed [31:0] fo4_q, fo5_q, fo6_q;
  logic signed [63:0] deltar_q;
  out_t              out_q, out_d;

  // Stage 1: spacing products and the coefficient product.
  logic [CFG_DATA_W-1:0] is1, is2;
  logic signed [63:0]    t1r_d, t2r_d, coefr_d;
  psi_pair_t             psi1_fwd, psi2_fwd, psi3_fwd;
  logic                  hit1, hit2, hit3;

  always_comb begin
    case (s1_q.mode)
      MODE_EX, MODE_HX: begin
        is1 = inv_dy_q;
        is2 = inv_dz_q;
      end
      MODE_EY, MODE_HY: begin
        is1 = inv_dz_q;
        is2 = inv_dx_q;
      end
      default: begin
        is1 = inv_dx_q;
        is2 = inv_dy_q;
      end
    endcase
    t1r_d = 64'(s1_q.diff1) * 64'($signed({1'b0, is1}));
    t2r_d = 64'(s1_q.diff2) * 64'($signed({1'b0, is2}));
    coefr_d = 64'($signed({1'b0, time_step_q})) * 64'($signed({1'b0, s1_q.inv_material}));
  end

  // The entry leaving stage 3 on the last edge sits in stage 4; any younger
  // transaction on the same cell picks up that value instead of its stale copy.
  assign hit1 = v4_q && c4_q.wr && (c4_q.cell_idx == c1_q.cell_idx);
  assign hit2 = v4_q && c4_q.wr && (c4_q.cell_idx == c2_q.cell_idx);
  assign hit3 = v4_q && c4_q.wr && (c4_q.cell_idx == c3_q.cell_idx);
  assign psi1_fwd = hit1 ? psin4_q : psi_rd;
  assign psi2_fwd = hit2 ? psin4_q : psi2_q;
  assign psi3_fwd = hit3 ? psin4_q : psi3_q;

  // Stage 2: rescale spacing terms, gain and kappa products.
  fx_t                t1, t2, coef;
  logic signed [63:0] gt1r_d, gt2r_d, st1r_d, st2r_d;

  always_comb begin
    t1 = fx_shift_sat(t1r_q);
    t2 = fx_shift_sat(t2r_q);
    coef = fx_shift_sat(coefr_q);
    gt1r_d = 64'(s2_q.gain1) * 64'(t1.val);
    gt2r_d = 64'(s2_q.gain2) * 64'(t2.val);
    st1r_d = 64'(t1.val) * 64'($signed({1'b0, s2_q.inv_kappa1}));
    st2r_d = 64'(t2.val) * 64'($signed({1'b0, s2_q.inv_kappa2}));
  end

  // Stage 3: psi update, written back at the end of the stage.
  psi_pair_t          p_old, psin_d;
  logic signed [63:0] dp1r, dp2r;
  fx_t                dp1, dp2, g1, g2, p1, p2, sk1, sk2;
  logic               f4_d;

  always_comb begin
    p_old = c3_q.in_range ? psi3_fwd : '0;
    dp1r = 64'($signed({1'b0, s3_q.decay1})) * 64'(p_old.first);
    dp2r = 64'($signed({1'b0, s3_q.decay2})) * 64'(p_old.second);
    dp1 = fx_shift_sat(dp1r);
    dp2 = fx_shift_sat(dp2r);
    g1 = fx_shift_sat(gt1r_q);
    g2 = fx_shift_sat(gt2r_q);
    p1 = fx_sat64(64'(dp1.val) + 64'(g1.val));
    p2 = fx_sat64(64'(dp2.val) + 64'(g2.val));
    psin_d.first = p1.val;
    psin_d.second = p2.val;
    sk1 = fx_shift_sat(st1r_q);
    sk2 = fx_shift_sat(st2r_q);
    f4_d = f3_q || dp1.sat || dp2.sat || g1.sat || g2.sat || p1.sat || p2.sat
        || sk1.sat || sk2.sat;
  end

  logic psi_we;
  assign psi_we = advance && v3_q && c3_q.wr;
  assign wr_idx = IDX_W'(c3_q.cell_idx);

  // Stage 4: total curl term.
  fx_t sum;
  assign sum = fx_sat64(64'(sk1_q) - 64'(sk2_q) + 64'(psin4_q.first) - 64'(psin4_q.second));

  // Stage 5: scale by the coefficient.
  logic signed [63:0] deltar_d;
  assign deltar_d = 64'(coef5_q) * 64'(sum5_q);

  // Stage 6: apply to the field.
  fx_t                delta, res;
  logic signed [63:0] res_raw;

  always_comb begin
    delta = fx_shift_sat(deltar_q);
    res_raw = c6_q.add ? (64'(fo6_q) + 64'(delta.val)) : (64'(fo6_q) - 64'(delta.val));
    res = fx_sat64(res_raw);
    if (c6_q.upd) begin
      out_d.field_new = res.val;
      out_d.saturated = f6_q || delta.sat || res.sat;
    end else begin
      out_d.field_new = fo6_q;
      out_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= in_data_i;
      c1_q <= ctl_in;

      s2_q <= s1_q;
      c2_q <= c1_q;
      t1r_q <= t1r_d;
      t2r_q <= t2r_d;
      coefr_q <= coefr_d;
      psi2_q <= psi1_fwd;

      s3_q <= s2_q;
      c3_q <= c2_q;
      psi3_q <= psi2_fwd;
      gt1r_q <= gt1r_d;
      gt2r_q <= gt2r_d;
      st1r_q <= st1r_d;
      st2r_q <= st2r_d;
      coef3_q <= coef.val;
      f3_q <= t1.sat || t2.sat || coef.sat;

      c4_q <= c3_q;
      psin4_q <= psin_d;
      sk1_q <= sk1.val;
      sk2_q <= sk2.val;
      coef4_q <= coef3_q;
      fo4_q <= s3_q.field_old;
      f4_q <= f4_d;

      c5_q <= c4_q;
      sum5_q <= sum.val;
      coef5_q <= coef4_q;
      fo5_q <= fo4_q;
      f5_q <= f4_q || sum.sat;

      c6_q <= c5_q;
      deltar_q <= deltar_d;
      fo6_q <= fo5_q;
      f6_q <= f5_q;

      if (v6_q) begin
        out_q <= out_d;
      end
    end
  end

  cpml_psi_mem #(
    .CELL_COUNT(CELL_COUNT)
  ) u_psi_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (advance),
    .rd_addr_i (rd_idx[ADDR_W-1:0]),
    .rd_data_o (psi_rd),
    .wr_en_i   (psi_we),
    .wr_addr_i (wr_idx[ADDR_W-1:0]),
    .wr_data_i (psin_d),
    .busy_o    (mem_busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `CPML_ASSERT_NOW(a_clear_empty, mem_busy, !pipe_busy, "transaction in flight during psi clear")
  `CPML_ASSERT_NEXT(a_hold_last, !advance, v6_q, "blocked last stage lost its transaction")
  `CPML_ASSERT_NOW(a_out_source, $rose(out_valid_q), $past(v6_q), "result from empty last stage")
  `CPML_ASSERT_NOW(a_wb_range, psi_we, c3_q.in_range && c3_q.upd && !mem_busy, "bad psi write")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cpml_pkg::*;

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Shadow copies of the spacing and time step registers.
  logic [30:0] spc_x = INV_D_RESET;
  logic [30:0] spc_y = INV_D_RESET;
  logic [30:0] spc_z = INV_D_RESET;
  logic [30:0] dt_q = TIME_STEP_RESET;

  int aux_first [DEF_CELL_COUNT];
  int aux_second [DEF_CELL_COUNT];

  in_t pending_cells[$];
  out_t predicted_fields[$];

  int send_max = 0;
  int recv_max = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int mismatches = 0;
  logic [11:0] last_cell = '0;

  cpml_field_update_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp32(input longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Q15.16 multiply: exact product, floor shift, then clamp.
  function automatic longint qmul(input longint a, input longint b, inout bit clipped);
    longint p;
    p = a * b;
    return clamp32(p >>> 16, clipped);
  endfunction

  // Predicts one field update and, for the six update modes, advances the auxiliary psi store of the cell.
  function automatic out_t field_update(input in_t x);
    out_t r;
    bit clip;
    longint fo, sp1, sp2, old1, old2, t1, t2, n1, n2, k1, k2, total, coef, delta, res;
    clip = 1'b0;
    fo = $signed(x.field_old);
    if (x.mode == MODE_RSVD6 || x.mode == MODE_RSVD7) begin
      r.field_new = x.field_old;
      r.saturated = 1'b0;
      return r;
    end
    case (x.mode)
      MODE_EX, MODE_HX: begin
        sp1 = spc_y;
        sp2 = spc_z;
      end
      MODE_EY, MODE_HY: begin
        sp1 = spc_z;
        sp2 = spc_x;
      end
      default: begin
        sp1 = spc_x;
        sp2 = spc_y;
      end
    endcase
    old1 = aux_first[x.cell_req];
    old2 = aux_second[x.cell_req];
    t1 = qmul($signed(x.diff1), sp1, clip);
    t2 = qmul($signed(x.diff2), sp2, clip);
    n1 = clamp32(qmul(x.decay1, old1, clip) + qmul($signed(x.gain1), t1, clip), clip);
    n2 = clamp32(qmul(x.decay2, old2, clip) + qmul($signed(x.gain2), t2, clip), clip);
    aux_first[x.cell_req] = int'(n1);
    aux_second[x.cell_req] = int'(n2);
    k1 = qmul(t1, x.inv_kappa1, clip);
    k2 = qmul(t2, x.inv_kappa2, clip);
    total = clamp32(k1 - k2 + n1 - n2, clip);
    coef = qmul(dt_q, x.inv_material, clip);
    delta = qmul(coef, total, clip);
    res = clamp32((x.mode < MODE_HX) ? fo + delta : fo - delta, clip);
    r.field_new = res[31:0];
    r.saturated = clip;
    return r;
  endfunction

  // Random value whose magnitude spans all scales, either sign.
  function automatic int varied();
    int v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [16:0] unit_coef();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'd65536;
      2: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
    // Revisit cells often so that psi builds up and back-to-back updates occur.
    case ($urandom_range(0, 9))
      0, 1: it.cell_req = last_cell;
      2, 3, 4, 5: it.cell_req = 12'($urandom_range(0, 15));
      default: it.cell_req = 12'($urandom);
    endcase
    last_cell = it.cell_req;
    it.field_old = varied();
    it.diff1 = varied();
    it.diff2 = varied();
    it.decay1 = unit_coef();
    it.decay2 = unit_coef();
    it.gain1 = varied();
    it.gain2 = varied();
    it.inv_kappa1 = unit_coef();
    it.inv_kappa2 = unit_coef();
    it.inv_material = 31'($urandom) >> $urandom_range(0, 30);
    return it;
  endfunction

  function automatic in_t mk(input logic [2:0] m, input logic [11:0] c, input int f,
                             input int d1, input int d2, input logic [16:0] b1,
                             input logic [16:0] b2, input int g1, input int g2,
                             input logic [16:0] k1, input logic [16:0] k2,
                             input logic [30:0] mat);
    in_t it;
    it.mode = m;
    it.cell_req = c;
    it.field_old = f;
    it.diff1 = d1;
    it.diff2 = d2;
    it.decay1 = b1;
    it.decay2 = b2;
    it.gain1 = g1;
    it.gain2 = g2;
    it.inv_kappa1 = k1;
    it.inv_kappa2 = k2;
    it.inv_material = mat;
    return it;
  endfunction

  // Sender: presents queued transactions and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_fields.push_back(field_update(in_data_i));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_cells.pop_front();
          send_wait = $urandom_range(0, send_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and applies back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_fields.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: field_new %0d saturated %0b",
                     out_data_o.field_new, out_data_o.saturated);
          end
        end else begin
          want = predicted_fields.pop_front();
          if (out_data_o.field_new !== want.field_new ||
              out_data_o.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: field_new exp %0d got %0d, saturated exp %0b got %0b",
                       want.field_new, out_data_o.field_new,
                       want.saturated, out_data_o.saturated);
            end
          end
        end
        recv_wait = $urandom_range(0, recv_max);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (recv_wait > 0) || (hold_left > 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** cpml_field_update_core: FAILED **");
    $finish;
  end

  task automatic drain();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || in_valid_i || predicted_fields.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_INV_DX: spc_x = val;
      CFG_INV_DY: spc_y = val;
      CFG_INV_DZ: spc_z = val;
      default: dt_q = val;
    endcase
  endtask

  task automatic run_phase(input logic [30:0] dx, input logic [30:0] dy,
                           input logic [30:0] dz, input logic [30:0] dt,
                           input int count, input int smax, input int rmax,
                           input bit long_hold);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_INV_DX, dx);
    write_reg(CFG_INV_DY, dy);
    write_reg(CFG_INV_DZ, dz);
    write_reg(CFG_TIME_STEP, dt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_max = smax;
    recv_max = rmax;
    if (long_hold) hold_req = 1'b1;
    repeat (count) pending_cells.push_back(random_item());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_max = 1;
    recv_max = 1;
    // Directed pass under the reset register values.
    pending_cells.push_back(mk(MODE_EX, 12'd0, 0, 32'sh10000, 32'sh8000, 17'h8000,
                               17'h8000, 32'sh10000, 32'sh10000, 17'h10000, 17'h10000,
                               31'h10000));
    pending_cells.push_back(mk(MODE_EY, 12'd1, 32'sh20000, -32'sh10000, 32'sh30000,
                               17'h8000, 17'h4000, 32'sh8000, -32'sh8000, 17'h8000,
                               17'h10000, 31'h10000));
    pending_cells.push_back(mk(MODE_EZ, 12'd2, -32'sh5000, 32'sh7, -32'sh3, 17'h1,
                               17'hFFFF, -32'sh10000, 32'sh20000, 17'h1, 17'hFFFF,
                               31'h20000));
    pending_cells.push_back(mk(MODE_HX, 12'd3, 32'sh1234, 32'sh40000, 32'sh10000,
                               17'h10000, 17'h0, 32'sh10000, 32'sh10000, 17'h10000,
                               17'h8000, 31'h8000));
    pending_cells.push_back(mk(MODE_HY, 12'd4, -32'sh1234, -32'sh40000, -32'sh1,
                               17'h0, 17'h10000, 32'sh4000, 32'sh4000, 17'h0, 17'h10000,
                               31'h30000));
    pending_cells.push_back(mk(MODE_HZ, 12'd5, 0, 32'sh18000, -32'sh18000, 17'hC000,
                               17'hC000, -32'sh10000, 32'sh10000, 17'h10000, 17'h10000,
                               31'h10000));
    // Unused modes leave psi alone and pass the field through.
    pending_cells.push_back(mk(MODE_RSVD6, 12'd6, 32'sh55555, 32'sh10000, 32'sh10000,
                               17'h10000, 17'h10000, 32'sh10000, 32'sh10000, 17'h10000,
                               17'h10000, 31'h10000));
    pending_cells.push_back(mk(MODE_RSVD7, 12'd0, -32'sh55555, -1, -1, 17'h1FFFF,
                               17'h1FFFF, -1, -1, 17'h1FFFF, 17'h1FFFF, 31'h7FFFFFFF));
    // Same cell on consecutive transactions.
    pending_cells.push_back(mk(MODE_EX, 12'd0, 0, 32'sh10000, 32'sh8000, 17'hF000,
                               17'hF000, 32'sh10000, 32'sh10000, 17'h10000, 17'h10000,
                               31'h10000));
    pending_cells.push_back(mk(MODE_EX, 12'd0, 0, 32'sh10000, 32'sh8000, 17'hF000,
                               17'hF000, 32'sh10000, 32'sh10000, 17'h10000, 17'h10000,
                               31'h10000));
    pending_cells.push_back(mk(MODE_HZ, 12'hFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                               -32'sh80000000, 17'h10000, 17'h10000, 32'sh7FFFFFFF,
                               32'sh7FFFFFFF, 17'h10000, 17'h10000, 31'h7FFFFFFF));
    pending_cells.push_back(mk(MODE_EX, 12'hFFF, -32'sh80000000, -32'sh80000000,
                               32'sh7FFFFFFF, 17'h10000, 17'h10000, -32'sh80000000,
                               -32'sh80000000, 17'h10000, 17'h10000, 31'h7FFFFFFF));
    pending_cells.push_back(mk(MODE_HY, 12'd100, 0, 0, 0, 17'h0, 17'h0, 0, 0, 17'h0,
                               17'h0, 31'h0));
    // Field result clips high for E and low for H.
    pending_cells.push_back(mk(MODE_EZ, 12'd100, 32'sh7FFF0000, 32'sh100000, 0, 17'h0,
                               17'h0, 0, 0, 17'h10000, 17'h0, 31'h7FFFFFFF));
    pending_cells.push_back(mk(MODE_HX, 12'd7, -32'sh7FFF0000, 32'sh100000, 0, 17'h0,
                               17'h0, 0, 0, 17'h10000, 17'h0, 31'h7FFFFFFF));
    pending_cells.push_back(mk(MODE_EY, 12'd7, 32'sh100, 32'sh20000, 32'sh30000,
                               17'h1FFFF, 17'h1FFFF, 32'sh30000, -32'sh30000, 17'h1FFFF,
                               17'h1FFFF, 31'h4000));
    pending_cells.push_back(mk(MODE_HX, 12'hFFF, 32'sh10, 32'sh10000, 32'sh10000,
                               17'h10000, 17'h10000, 32'sh10000, 32'sh10000, 17'h10000,
                               17'h10000, 31'h10000));
    pending_cells.push_back(mk(MODE_EX, 12'hFFF, 32'sh10, 32'sh10000, 32'sh10000,
                               17'h10000, 17'h10000, 32'sh10000, 32'sh10000, 17'h10000,
                               17'h10000, 31'h10000));

    run_phase(31'($urandom_range(1 << 12, 1 << 18)), 31'($urandom_range(1 << 12, 1 << 18)),
              31'($urandom_range(1 << 12, 1 << 18)), 31'($urandom_range(0, 1 << 17)),
              140, 3, 3, 1'b0);
    // Register extremes with neither side idling.
    run_phase(31'h0, 31'h7FFFFFFF, 31'h1, 31'h7FFFFFFF, 50, 0, 0, 1'b0);
    // The receiver holds off for a long stretch while transactions keep coming.
    run_phase(31'h10000, 31'h8000, 31'h20000, 31'h4000, 80, 0, 3, 1'b1);
    run_phase(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom), 120, 3, 3, 1'b0);
    run_phase(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h0, 40, 1, 0, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && predicted_fields.size() == 0) begin
      $display("** cpml_field_update_core: PASSED **");
    end else begin
      $display("** cpml_field_update_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cpml_pkg.sv
rtl/cpml_psi_mem.sv
rtl/cpml_field_update_core.sv
tb/sv/testbench.sv
